// File: src/sorted_key_table_search_core_assert.svh
// Assertion macros for the sorted key table search core.
// The including module supplies clk and rst.
`ifndef SORTED_KEY_TABLE_SEARCH_CORE_ASSERT_SVH
`define SORTED_KEY_TABLE_SEARCH_CORE_ASSERT_SVH

// Same-cycle implication, held off during reset
`define SKTS_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted key table check failed");

// Next-cycle implication, held off during reset
`define SKTS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted key table check failed");

`endif

// File: src/skts_pkg.sv
package skts_pkg;

  // Field widths of the item formats
  localparam int KH_W   = 16;
  localparam int KL_W   = 64;
  localparam int PL_W   = 48;
  localparam int ACT_W  = 2;
  localparam int POS_W  = 4;
  localparam int STAT_W = 2;
  localparam int FIDX_W = 4;

  localparam int DEPTH_DEF = 16;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD   = 2'd0,
    ACT_SORT   = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_READ   = 2'd3
  } skts_action_t;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_MISS  = 2'd1,
    STATUS_FULL  = 2'd2,
    STATUS_RANGE = 2'd3
  } skts_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SORT,
    S_PROBE,
    S_MEM_WAIT,
    S_MEM_USE,
    S_EMIT
  } skts_state_t;

  typedef struct packed {
    logic [KH_W-1:0] key_high;
    logic [KL_W-1:0] key_low;
    logic [PL_W-1:0] payload;
  } skts_entry_t;

  // Broadcast controls from the sequencer to the row of cells
  typedef struct packed {
    logic wr;
    logic start;
  } skts_ctl_t;

  typedef struct packed {
    skts_status_t        status;
    logic [FIDX_W-1:0]   index;
    skts_entry_t         entry;
  } skts_result_t;

  // Unsigned 80-bit key compare, a strictly greater than b
  function automatic logic key_gt(skts_entry_t a, skts_entry_t b);
    return {a.key_high, a.key_low} > {b.key_high, b.key_low};
  endfunction

endpackage

// File: src/skts_if.sv
// Request channel: one action per item
interface skts_req_if;
  logic                        valid;
  logic                        ready;
  logic [skts_pkg::ACT_W-1:0]  action;
  logic [skts_pkg::KH_W-1:0]   key_high;
  logic [skts_pkg::KL_W-1:0]   key_low;
  logic [skts_pkg::PL_W-1:0]   payload;
  logic [skts_pkg::POS_W-1:0]  position;

  modport source (output valid, action, key_high, key_low, payload, position,
                  input ready);
  modport sink   (input valid, action, key_high, key_low, payload, position,
                  output ready);
endinterface

// Response channel: one result item per request
interface skts_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [skts_pkg::STAT_W-1:0] status;
  logic [skts_pkg::FIDX_W-1:0] found_index;
  logic [skts_pkg::KH_W-1:0]   out_key_high;
  logic [skts_pkg::KL_W-1:0]   out_key_low;
  logic [skts_pkg::PL_W-1:0]   out_payload;

  modport source (output valid, status, found_index, out_key_high, out_key_low,
                  out_payload, input ready);
  modport sink   (input valid, status, found_index, out_key_high, out_key_low,
                  out_payload, output ready);
endinterface

// File: src/skts_cell.sv
// One table entry. During a sort pass a carried record walks the row one cell
// a cycle; a live cell keeps the larger key and hands the smaller one on.
module skts_cell #(
  parameter int DEPTH = skts_pkg::DEPTH_DEF,
  parameter int INDEX = 0,
  localparam int IW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  skts_pkg::skts_ctl_t   ctl,
  input  logic [IW-1:0]         wr_idx,
  input  logic [IW-1:0]         start_idx,
  input  logic [CW-1:0]         fill,
  input  skts_pkg::skts_entry_t wr_data,
  input  skts_pkg::skts_entry_t carry_in,
  input  logic                  act_in,
  output skts_pkg::skts_entry_t carry_out,
  output logic                  act_out,
  output skts_pkg::skts_entry_t entry
);
  import skts_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);
  localparam logic [CW-1:0] MY_POS = CW'(INDEX);

  logic live;
  logic swap;
  logic launch;

  // Cells beyond the fill just pass the carry through
  assign live   = MY_POS < fill;
  assign swap   = act_in && live && key_gt(carry_in, entry);
  assign launch = ctl.start && (start_idx == MY_IDX);

  // Stored record: direct write, or take the larger carried record
  always_ff @(posedge clk) begin
    if (ctl.wr && (wr_idx == MY_IDX)) begin
      entry <= wr_data;
    end else if (swap) begin
      entry <= carry_in;
    end
  end

  // Carried record towards the next cell
  always_ff @(posedge clk) begin
    if (launch || swap) begin
      carry_out <= entry;
    end else begin
      carry_out <= carry_in;
    end
  end

  // Pass token
  always_ff @(posedge clk) begin
    if (rst) begin
      act_out <= 1'b0;
    end else begin
      act_out <= launch || act_in;
    end
  end

endmodule

// File: src/sorted_key_table_search_core.sv
// Load: written into the row on accept. Read: through the registered row read.
// Lookup: binary search over the registered row read, up to log2(DEPTH)+1 probes.
// Sort over n entries: n-1 passes, each one cell shorter than the last.
// One item at a time; a new item is taken while a result waits at the output.
// Synchronous reset empties the table and clears control; entries keep old data.
module sorted_key_table_search_core #(
  parameter int DEPTH = skts_pkg::DEPTH_DEF
) (
  input logic      clk,
  input logic      rst,
  skts_req_if.sink   req,
  skts_rsp_if.source rsp
);
  import skts_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0]        FULL_CNT = CW'(DEPTH);
  localparam logic [CW-1:0]        TWO_CNT  = CW'(2);
  localparam logic signed [CW:0]   ONE_S    = (CW+1)'(1);

  skts_state_t  state, state_next;
  logic [CW-1:0] fill, fill_next;
  logic [IW-1:0] cur, cur_next;
  logic signed [CW:0] lo, lo_next, hi, hi_next;
  skts_entry_t  query, query_next;
  skts_action_t op, op_next;
  logic [IW-1:0] rd_addr, rd_addr_next;
  skts_entry_t  rd_data;
  skts_result_t res, res_next, rsp_res;
  logic         rsp_valid;
  logic         load_out;
  logic         req_ready;
  logic         load_take;

  skts_ctl_t     ctl;
  logic [IW-1:0] wr_idx, start_idx;
  skts_entry_t   wr_data;
  logic [CW+1:0] probe_sum;
  logic [IW-1:0] mid;
  logic signed [CW:0] mid_s;

  skts_entry_t   c_carry [DEPTH+1];
  logic [DEPTH:0] c_act;
  skts_entry_t   entries [DEPTH];

  // Row of cells, chained through carry and token
  assign c_carry[0] = '0;
  assign c_act[0]   = 1'b0;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    skts_cell #(.DEPTH(DEPTH), .INDEX(k)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .wr_idx    (wr_idx),
      .start_idx (start_idx),
      .fill      (fill),
      .wr_data   (wr_data),
      .carry_in  (c_carry[k]),
      .act_in    (c_act[k]),
      .carry_out (c_carry[k+1]),
      .act_out   (c_act[k+1]),
      .entry     (entries[k])
    );
  end

  // Registered read port on the row
  always_ff @(posedge clk) begin
    rd_data <= entries[rd_addr];
  end

  // Probe midpoint; lo and hi are both non-negative whenever it is used
  assign probe_sum = {1'b0, lo} + {1'b0, hi};
  assign mid       = probe_sum[IW:1];
  assign mid_s     = $signed({1'b0, CW'(rd_addr)});

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    cur     <= cur_next;
    lo      <= lo_next;
    hi      <= hi_next;
    query   <= query_next;
    op      <= op_next;
    rd_addr <= rd_addr_next;
    res     <= res_next;
  end

  // Next state and row controls
  always_comb begin
    state_next   = state;
    fill_next    = fill;
    cur_next     = cur;
    lo_next      = lo;
    hi_next      = hi;
    query_next   = query;
    op_next      = op;
    rd_addr_next = rd_addr;
    res_next     = res;
    ctl          = '0;
    wr_idx       = cur;
    start_idx    = '0;
    wr_data      = c_carry[DEPTH];
    req_ready    = 1'b0;
    load_out     = 1'b0;

    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req.valid) begin
          op_next    = skts_action_t'(req.action);
          query_next = '{key_high: req.key_high, key_low: req.key_low,
                         payload: req.payload};
          res_next   = '{status: STATUS_OK, index: '0, entry: '0};
          state_next = S_EMIT;
          case (skts_action_t'(req.action))
            ACT_LOAD: begin
              if (fill == FULL_CNT) begin
                res_next.status = STATUS_FULL;
              end else begin
                ctl.wr    = 1'b1;
                wr_idx    = IW'(fill);
                wr_data   = '{key_high: req.key_high, key_low: req.key_low,
                              payload: req.payload};
                fill_next = fill + 1'b1;
              end
            end
            ACT_SORT: begin
              if (fill >= TWO_CNT) begin
                ctl.start  = 1'b1;
                start_idx  = '0;
                cur_next   = '0;
                state_next = S_SORT;
              end
            end
            ACT_LOOKUP: begin
              lo_next    = '0;
              hi_next    = $signed({1'b0, fill}) - ONE_S;
              state_next = S_PROBE;
            end
            ACT_READ: begin
              if (PW'(req.position) >= PW'(fill)) begin
                res_next.status = STATUS_RANGE;
              end else begin
                rd_addr_next = IW'(req.position);
                state_next   = S_MEM_WAIT;
              end
            end
            default: state_next = S_EMIT;
          endcase
        end
      end

      // Pass done when the token leaves the row: park the carry at cur
      S_SORT: begin
        if (c_act[DEPTH]) begin
          ctl.wr  = 1'b1;
          wr_idx  = cur;
          wr_data = c_carry[DEPTH];
          if ((CW+1)'(cur) + (CW+1)'(2) < {1'b0, fill}) begin
            ctl.start = 1'b1;
            start_idx = cur + 1'b1;
            cur_next  = cur + 1'b1;
          end else begin
            state_next = S_EMIT;
          end
        end
      end

      S_PROBE: begin
        if (lo > hi) begin
          res_next.status = STATUS_MISS;
          state_next      = S_EMIT;
        end else begin
          rd_addr_next = mid;
          state_next   = S_MEM_WAIT;
        end
      end

      S_MEM_WAIT: state_next = S_MEM_USE;

      S_MEM_USE: begin
        if (op == ACT_READ) begin
          res_next   = '{status: STATUS_OK, index: FIDX_W'(rd_addr), entry: rd_data};
          state_next = S_EMIT;
        end else if ({query.key_high, query.key_low} ==
                     {rd_data.key_high, rd_data.key_low}) begin
          res_next   = '{status: STATUS_OK, index: FIDX_W'(rd_addr), entry: rd_data};
          state_next = S_EMIT;
        end else begin
          if ({query.key_high, query.key_low} < {rd_data.key_high, rd_data.key_low}) begin
            hi_next = mid_s - ONE_S;
          end else begin
            lo_next = mid_s + ONE_S;
          end
          state_next = S_PROBE;
        end
      end

      S_EMIT: begin
        if (!rsp_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp_res <= res;
    end
  end

  assign req.ready        = req_ready;
  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_res.status;
  assign rsp.found_index  = rsp_res.index;
  assign rsp.out_key_high = rsp_res.entry.key_high;
  assign rsp.out_key_low  = rsp_res.entry.key_low;
  assign rsp.out_payload  = rsp_res.entry.payload;

  // Load item taken into a table with room
  assign load_take = req.valid && req_ready && (req.action == ACT_LOAD) &&
                     (fill != FULL_CNT);

  // Checks
  `include "sorted_key_table_search_core_assert.svh"

  `SKTS_ASSERT_NOW(a_one_token, 1'b1, $onehot0(c_act[DEPTH:1]))
  `SKTS_ASSERT_NOW(a_token_in_sort, c_act[DEPTH], state == S_SORT)
  `SKTS_ASSERT_NEXT(a_load_counts, load_take, fill == CW'($past(fill) + 1'b1))
  `SKTS_ASSERT_NEXT(a_emit_drains, load_out, rsp_valid && state == S_IDLE)

endmodule
